>>> rtl/mosl_pkg.sv
// ----------------------------------------------------------------------------
// mosl_pkg
// Shared constants and control types for the two-list median block.
// ----------------------------------------------------------------------------
package mosl_pkg;

	localparam int unsigned LIST_DEPTH_DEF = 1024;
	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned RESULT_W       = 33;

	localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [1:0] OP_COMPUTE     = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	typedef struct packed {
		logic load_first;
		logic load_second;
		logic emit_special;
		logic start;
		logic step;
		logic finish;
	} mosl_cmd_t;

	typedef struct packed {
		logic special;
		logic last_step;
		logic out_busy;
	} mosl_sts_t;

endpackage

>>> rtl/mosl_ram.sv
// ----------------------------------------------------------------------------
// mosl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mosl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/mosl_ctrl.sv
// ----------------------------------------------------------------------------
// mosl_ctrl
// Controller: accepts requests and sequences the merge walk.
// ----------------------------------------------------------------------------
module mosl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [1:0]           op,
	input  mosl_pkg::mosl_sts_t  sts,
	output mosl_pkg::mosl_cmd_t  cmd
);

	import mosl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		accept        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = !((op == OP_COMPUTE) && sts.out_busy);
				accept        = s_axis_tvalid && s_axis_tready;
				if (accept) begin
					unique case (op)
						OP_LOAD_FIRST: begin
							cmd.load_first = 1'b1;
						end
						OP_LOAD_SECOND: begin
							cmd.load_second = 1'b1;
						end
						OP_COMPUTE: begin
							if (sts.special) begin
								cmd.emit_special = 1'b1;
							end else begin
								cmd.start = 1'b1;
								state_d   = ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (sts.last_step) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/mosl_dp.sv
// ----------------------------------------------------------------------------
// mosl_dp
// Datapath: list storage, counts, merge pointers and the result register.
// ----------------------------------------------------------------------------
module mosl_dp #(
	parameter int unsigned LIST_DEPTH = mosl_pkg::LIST_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          value,
	input  mosl_pkg::mosl_cmd_t  cmd,
	output mosl_pkg::mosl_sts_t  sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [32:0]          median_doubled,
	output logic [1:0]           status
);

	import mosl_pkg::*;

	localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

	logic [CW-1:0]        cnt1_q, cnt2_q;
	logic [CW-1:0]        i_q, j_q, pos_q;
	logic [CW-1:0]        i_d, j_d;
	logic                 ovf_q;
	logic                 out_valid_q;
	logic signed [31:0]   prev_q;
	logic [32:0]          res_q;
	logic [1:0]           status_q;
	logic [CW:0]          total;
	logic [CW-1:0]        hi_pos;
	logic [31:0]          rd1, rd2;
	logic signed [31:0]   head1, head2, pick;
	logic                 take_first;
	logic                 we1, we2;
	logic [32:0]          walk_res;

	assign total  = {1'b0, cnt1_q} + {1'b0, cnt2_q};
	assign hi_pos = total[CW:1];
	assign head1  = rd1;
	assign head2  = rd2;

	assign take_first = (i_q < cnt1_q) && ((j_q >= cnt2_q) || (head1 < head2));
	assign pick       = take_first ? head1 : head2;

	assign walk_res = total[0] ? {pick, 1'b0}
		: ({prev_q[31], prev_q} + {pick[31], pick});

	assign we1 = cmd.load_first && (cnt1_q < DEPTH_C);
	assign we2 = cmd.load_second && (cnt2_q < DEPTH_C);

	always_comb begin
		i_d = i_q;
		j_d = j_q;
		if (cmd.start) begin
			i_d = '0;
			j_d = '0;
		end else if (cmd.step) begin
			if (take_first) begin
				i_d = i_q + CW'(1);
			end else begin
				j_d = j_q + CW'(1);
			end
		end
	end

	mosl_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_first_ram (
		.clk   (clk),
		.we    (we1),
		.waddr (cnt1_q[AW-1:0]),
		.wdata (value),
		.raddr (i_d[AW-1:0]),
		.rdata (rd1)
	);

	mosl_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_second_ram (
		.clk   (clk),
		.we    (we2),
		.waddr (cnt2_q[AW-1:0]),
		.wdata (value),
		.raddr (j_d[AW-1:0]),
		.rdata (rd2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q      <= '0;
			cnt2_q      <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			i_q <= i_d;
			j_q <= j_d;
			if (cmd.load_first) begin
				if (we1) begin
					cnt1_q <= cnt1_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.load_second) begin
				if (we2) begin
					cnt2_q <= cnt2_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				pos_q <= '0;
			end else if (cmd.step) begin
				pos_q <= pos_q + CW'(1);
			end
			if (cmd.emit_special || cmd.finish) begin
				cnt1_q      <= '0;
				cnt2_q      <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			prev_q <= pick;
		end
		if (cmd.emit_special) begin
			res_q    <= '0;
			status_q <= ovf_q ? STAT_OVERFLOW : STAT_EMPTY;
		end else if (cmd.finish) begin
			res_q    <= walk_res;
			status_q <= STAT_OK;
		end
	end

	assign sts.special   = ovf_q || (total == '0);
	assign sts.last_step = (pos_q == hi_pos);
	assign sts.out_busy  = out_valid_q;

	assign out_valid      = out_valid_q;
	assign median_doubled = res_q;
	assign status         = status_q;

endmodule

>>> rtl/median_of_two_sorted_lists.sv
// A load is written to its list on acceptance; a compute on an empty or overflowed set gives
// its result in the cycle after acceptance, otherwise once the merge walk ends.
// Throughput: one load per cycle while idle; a compute holds off input until its walk ends,
// one merge step per cycle through the registered read port of each list RAM.
// Reset clears the counts, the overflow flag, the controller and the output valid;
// list contents are not cleared.
// ----------------------------------------------------------------------------
// median_of_two_sorted_lists
// Collects two sorted lists and returns twice their joint median by merge walk.
// ----------------------------------------------------------------------------
module median_of_two_sorted_lists #(
	parameter int unsigned LIST_DEPTH = mosl_pkg::LIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [32:0] median_doubled, [39:33] zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	import mosl_pkg::*;

	mosl_cmd_t   cmd;
	mosl_sts_t   sts;
	logic [32:0] median_doubled;

	mosl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.op            (s_axis_tuser),
		.sts           (sts),
		.cmd           (cmd)
	);

	mosl_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.value          (s_axis_tdata),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.median_doubled (median_doubled),
		.status         (m_axis_tuser)
	);

	assign m_axis_tdata = {7'd0, median_doubled};

endmodule
